// ===== rtl/hac_pkg.sv =====
package hac_pkg;

    // Datapath sizes
    localparam int ANGLE_W         = 16;
    localparam int WEIGHT_W        = 16;
    localparam int TRIG_W          = 16;
    localparam int MAG_W           = 15;
    localparam int PROD_W          = WEIGHT_W + TRIG_W;
    localparam int ACC_W           = PROD_W + 2;
    localparam int CORR_SHIFT      = 15;

    // Harmonic model
    localparam int HARMONICS       = 3;
    localparam int WEIGHT_SETS     = 3;
    localparam int HARM_W          = 2;
    localparam int TRIG_PHASE_BITS = 12;
    localparam int QTR_BITS        = TRIG_PHASE_BITS - 2;
    localparam int QTR_LEN         = 1 << QTR_BITS;

    // Register map
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 5;
    localparam int REG_IDX_W       = 3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DC_OFFSET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIN_W1    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COS_W1    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIN_W2    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COS_W2    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SIN_W3    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COS_W3    = 3'd7;

    // Quadrant codes of the trig phase
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Beat handed from one cell to the next
    typedef struct packed {
        logic                     valid;
        logic [ANGLE_W-1:0]       angle;
        logic signed [ACC_W-1:0]  acc;
    } hac_beat_t;

    typedef logic [MAG_W-1:0] trig_mag_t;
    typedef trig_mag_t qwave_t [QTR_LEN];

    // Fixed-point constants for table generation (Q60)
    localparam logic [63:0] HALFPI_Q60   = 64'h1921FB54442D1847;
    localparam logic [63:0] ONE_Q60      = 64'h1000000000000000;
    localparam int          TAYLOR_TERMS = 14;

    // (a*b) >> 60, low 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Divide a Taylor term by j*(j+1)
    function automatic logic [63:0] term_div(input logic [63:0] v, input int j);
        logic [63:0] res;
        case (j)
            1:       res = v / 64'd2;
            2:       res = v / 64'd6;
            3:       res = v / 64'd12;
            4:       res = v / 64'd20;
            5:       res = v / 64'd30;
            6:       res = v / 64'd42;
            7:       res = v / 64'd56;
            8:       res = v / 64'd72;
            9:       res = v / 64'd90;
            10:      res = v / 64'd110;
            11:      res = v / 64'd132;
            12:      res = v / 64'd156;
            13:      res = v / 64'd182;
            14:      res = v / 64'd210;
            15:      res = v / 64'd240;
            16:      res = v / 64'd272;
            17:      res = v / 64'd306;
            18:      res = v / 64'd342;
            19:      res = v / 64'd380;
            20:      res = v / 64'd420;
            21:      res = v / 64'd462;
            22:      res = v / 64'd506;
            23:      res = v / 64'd552;
            24:      res = v / 64'd600;
            25:      res = v / 64'd650;
            26:      res = v / 64'd702;
            27:      res = v / 64'd756;
            28:      res = v / 64'd812;
            default: res = v;
        endcase
        return res;
    endfunction

    // Taylor series on a quarter wave; odd selects sine. Clamped to [0, 1].
    function automatic logic [63:0] series_q60(input logic [63:0] x, input logic odd);
        logic [63:0] x2;
        logic [63:0] t;
        longint      sum;
        int          n;
        x2  = mul_q60(x, x);
        t   = odd ? x : ONE_Q60;
        sum = longint'(t);
        n   = odd ? 1 : 0;
        for (int i = 1; i <= TAYLOR_TERMS; i++) begin
            t = term_div(mul_q60(t, x2), n + 1);
            n = n + 2;
            if ((i % 2) == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q60))
            sum = longint'(ONE_Q60);
        return 64'(sum);
    endfunction

    // round(32767 * v)
    function automatic trig_mag_t scale_round(input logic [63:0] v);
        logic [63:0] q40;
        logic [63:0] scaled;
        q40    = v >> 20;
        scaled = (q40 * 64'd32767 + (64'd1 << 39)) >> 40;
        return scaled[MAG_W-1:0];
    endfunction

    // Quarter-wave magnitude table, built at elaboration
    function automatic qwave_t build_wave(input logic odd);
        qwave_t      tab;
        logic [63:0] frac;
        logic [63:0] x;
        for (int r = 0; r < QTR_LEN; r++) begin
            frac   = 64'(r) << (62 - TRIG_PHASE_BITS);
            x      = mul_q60(frac, HALFPI_Q60);
            tab[r] = scale_round(series_q60(x, odd));
        end
        return tab;
    endfunction

    localparam qwave_t SIN_TABLE = build_wave(1'b1);
    localparam qwave_t COS_TABLE = build_wave(1'b0);

endpackage

// ===== rtl/hac_cell.sv =====
module hac_cell
    import hac_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [HARM_W-1:0]           harm,
    input  logic signed [WEIGHT_W-1:0]  sin_weight,
    input  logic signed [WEIGHT_W-1:0]  cos_weight,
    input  hac_beat_t                   beat_in,
    output logic                        beat_in_stall,
    output hac_beat_t                   beat_out,
    input  logic                        beat_out_stall
);

    // Stage 1: phase lookup
    logic                        v1_reg;
    logic [ANGLE_W-1:0]          angle1_reg;
    logic signed [ACC_W-1:0]     acc1_reg;
    logic [1:0]                  quad1_reg;
    trig_mag_t                   smag1_reg;
    trig_mag_t                   cmag1_reg;

    // Stage 2: weighted products
    logic                        v2_reg;
    logic [ANGLE_W-1:0]          angle2_reg;
    logic signed [ACC_W-1:0]     acc2_reg;
    logic signed [PROD_W-1:0]    sprod2_reg;
    logic signed [PROD_W-1:0]    cprod2_reg;

    // Stage 3: accumulate
    logic                        v3_reg;
    logic [ANGLE_W-1:0]          angle3_reg;
    logic signed [ACC_W-1:0]     acc3_reg;

    logic                        ready1;
    logic                        ready2;
    logic                        ready3;
    logic [ANGLE_W+HARM_W-1:0]   ka_full;
    logic [TRIG_PHASE_BITS-1:0]  phase;
    logic [QTR_BITS-1:0]         qidx;
    logic signed [TRIG_W-1:0]    sv;
    logic signed [TRIG_W-1:0]    cv;
    logic signed [TRIG_W-1:0]    s_fold;
    logic signed [TRIG_W-1:0]    c_fold;

    // Bubble-collapsing flow control
    assign ready3        = !v3_reg || !beat_out_stall;
    assign ready2        = !v2_reg || ready3;
    assign ready1        = !v1_reg || ready2;
    assign beat_in_stall = !ready1;

    // Harmonic phase: top bits of k*angle mod one turn
    assign ka_full = {{HARM_W{1'b0}}, beat_in.angle} * {{ANGLE_W{1'b0}}, harm};
    assign phase   = ka_full[ANGLE_W-1 -: TRIG_PHASE_BITS];
    assign qidx    = phase[QTR_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ready1)
            v1_reg <= beat_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && beat_in.valid)
        begin
            angle1_reg <= beat_in.angle;
            acc1_reg   <= beat_in.acc;
            quad1_reg  <= phase[TRIG_PHASE_BITS-1 -: 2];
            smag1_reg  <= SIN_TABLE[qidx];
            cmag1_reg  <= COS_TABLE[qidx];
        end
    end

    // Quadrant folding
    assign sv = {1'b0, smag1_reg};
    assign cv = {1'b0, cmag1_reg};

    always_comb
    begin
        case (quad1_reg)
            QUAD_0:
            begin
                s_fold = sv;
                c_fold = cv;
            end
            QUAD_1:
            begin
                s_fold = cv;
                c_fold = -sv;
            end
            QUAD_2:
            begin
                s_fold = -sv;
                c_fold = -cv;
            end
            default:
            begin
                s_fold = -cv;
                c_fold = sv;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ready2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            angle2_reg <= angle1_reg;
            acc2_reg   <= acc1_reg;
            sprod2_reg <= sin_weight * s_fold;
            cprod2_reg <= cos_weight * c_fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ready3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            angle3_reg <= angle2_reg;
            acc3_reg   <= acc2_reg + ACC_W'(sprod2_reg) + ACC_W'(cprod2_reg);
        end
    end

    assign beat_out.valid = v3_reg;
    assign beat_out.angle = angle3_reg;
    assign beat_out.acc   = acc3_reg;

    // Stall upstream only when every stage holds a beat and the exit is blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        beat_in_stall |-> (v1_reg && v2_reg && v3_reg && beat_out_stall))
        else $error("cell stalls with a free stage");

    // A blocked exit beat keeps its sum
    a_hold_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && beat_out_stall) |=> (v3_reg && $stable(acc3_reg)
                                        && $stable(angle3_reg)))
        else $error("exit beat changed while blocked");

    // A beat in the product stage is never dropped when the last stage frees
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ready3) |=> v3_reg)
        else $error("beat lost between product and sum stages");

endmodule

// ===== rtl/harmonic_angle_corrector_unit.sv =====
// Throughput: one beat per cycle while corr_stall is low; each harmonic cell is a three-stage pipe
// (table lookup, two 16x16 multiplies, accumulate) and the chain never recirculates.
// Stalls collapse bubbles, so new beats enter while a result waits at the output.
// Reset (rst_n, async low) clears all valid flags and every config register to zero.
module harmonic_angle_corrector_unit
    import hac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // Config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    // Raw angle channel
    input  logic                raw_valid,
    output logic                raw_stall,
    input  logic [ANGLE_W-1:0]  sensor_angle,

    // Corrected angle channel
    output logic                corr_valid,
    input  logic                corr_stall,
    output logic [ANGLE_W-1:0]  corrected_angle
);

    logic                        enable_reg;
    logic signed [WEIGHT_W-1:0]  dc_offset_reg;
    logic signed [WEIGHT_W-1:0]  sin_weight_reg [WEIGHT_SETS];
    logic signed [WEIGHT_W-1:0]  cos_weight_reg [WEIGHT_SETS];

    logic                        wr_en;
    logic [REG_IDX_W-1:0]        reg_idx;

    hac_beat_t                   chain_beat  [HARMONICS+1];
    logic                        chain_stall [HARMONICS+1];

    logic                        corr_valid_reg;
    logic [ANGLE_W-1:0]          corrected_angle_reg;
    logic [ANGLE_W-1:0]          corrected_next;
    logic                        out_ready;
    hac_beat_t                   last_beat;

    // Register write
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            dc_offset_reg <= '0;
            for (int i = 0; i < WEIGHT_SETS; i++)
            begin
                sin_weight_reg[i] <= '0;
                cos_weight_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:    enable_reg        <= pwdata[0];
                REG_DC_OFFSET: dc_offset_reg     <= pwdata[WEIGHT_W-1:0];
                REG_SIN_W1:    sin_weight_reg[0] <= pwdata[WEIGHT_W-1:0];
                REG_COS_W1:    cos_weight_reg[0] <= pwdata[WEIGHT_W-1:0];
                REG_SIN_W2:    sin_weight_reg[1] <= pwdata[WEIGHT_W-1:0];
                REG_COS_W2:    cos_weight_reg[1] <= pwdata[WEIGHT_W-1:0];
                REG_SIN_W3:    sin_weight_reg[2] <= pwdata[WEIGHT_W-1:0];
                REG_COS_W3:    cos_weight_reg[2] <= pwdata[WEIGHT_W-1:0];
                default:       enable_reg        <= enable_reg;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, enable_reg};
            REG_DC_OFFSET: prdata = DATA_W'(dc_offset_reg);
            REG_SIN_W1:    prdata = DATA_W'(sin_weight_reg[0]);
            REG_COS_W1:    prdata = DATA_W'(cos_weight_reg[0]);
            REG_SIN_W2:    prdata = DATA_W'(sin_weight_reg[1]);
            REG_COS_W2:    prdata = DATA_W'(cos_weight_reg[1]);
            REG_SIN_W3:    prdata = DATA_W'(sin_weight_reg[2]);
            REG_COS_W3:    prdata = DATA_W'(cos_weight_reg[2]);
            default:       prdata = '0;
        endcase
    end

    // Chain entry: accumulator starts at zero
    assign chain_beat[0].valid = raw_valid;
    assign chain_beat[0].angle = sensor_angle;
    assign chain_beat[0].acc   = '0;
    assign raw_stall           = chain_stall[0];

    // One cell per harmonic
    for (genvar h = 0; h < HARMONICS; h++)
    begin : g_cell
        hac_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .harm           (HARM_W'(h + 1)),
            .sin_weight     (sin_weight_reg[h]),
            .cos_weight     (cos_weight_reg[h]),
            .beat_in        (chain_beat[h]),
            .beat_in_stall  (chain_stall[h]),
            .beat_out       (chain_beat[h+1]),
            .beat_out_stall (chain_stall[h+1])
        );
    end

    // Output stage: floor(acc / 2^15), add offset, subtract mod one turn
    assign last_beat              = chain_beat[HARMONICS];
    assign out_ready              = !corr_valid_reg || !corr_stall;
    assign chain_stall[HARMONICS] = !out_ready;

    assign corrected_next = enable_reg
        ? (last_beat.angle - last_beat.acc[CORR_SHIFT +: ANGLE_W] - dc_offset_reg)
        : last_beat.angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            corr_valid_reg <= 1'b0;
        else if (out_ready)
            corr_valid_reg <= last_beat.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && last_beat.valid)
            corrected_angle_reg <= corrected_next;
    end

    assign corr_valid      = corr_valid_reg;
    assign corrected_angle = corrected_angle_reg;

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import hac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 3 * HARMONICS + 1;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_BLOCK = 110;

    // One accepted raw beat and the corrected angle it must produce
    typedef struct packed {
        logic [ANGLE_W-1:0] raw;
        logic [ANGLE_W-1:0] want;
    } pending_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                raw_valid = 1'b0;
    logic                raw_stall;
    logic [ANGLE_W-1:0]  sensor_angle = '0;
    logic                corr_valid;
    logic                corr_stall = 1'b0;
    logic [ANGLE_W-1:0]  corrected_angle;

    // Shadow copy of the register file
    logic                       cfg_enable;
    logic signed [WEIGHT_W-1:0] cfg_dc;
    logic signed [WEIGHT_W-1:0] cfg_sin [WEIGHT_SETS];
    logic signed [WEIGHT_W-1:0] cfg_cos [WEIGHT_SETS];

    // Quarter-wave magnitudes, round(32767*sin/cos)
    int sin_mag [QTR_LEN];
    int cos_mag [QTR_LEN];

    pending_t expected_angles [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int settings_used = 0;
    int reads_checked = 0;

    harmonic_angle_corrector_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .raw_valid       (raw_valid),
        .raw_stall       (raw_stall),
        .sensor_angle    (sensor_angle),
        .corr_valid      (corr_valid),
        .corr_stall      (corr_stall),
        .corrected_angle (corrected_angle)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // Fixed-point sine/cosine, Q60
    // ---------------------------------------------------------------

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return full[123:60];
    endfunction

    // Taylor sum over a quarter wave, clamped to [0, 1]
    function automatic logic [63:0] quarter_series(input logic [63:0] x, input bit sine);
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] order;
        longint      acc;
        int          i;
        x_sq  = fx_mul(x, x);
        term  = sine ? x : ONE_Q60;
        acc   = longint'(term);
        order = sine ? 64'd1 : 64'd0;
        for (i = 1; i <= TAYLOR_TERMS; i++)
        begin
            term  = fx_mul(term, x_sq) / ((order + 64'd1) * (order + 64'd2));
            order = order + 64'd2;
            if (i[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(ONE_Q60))
            acc = longint'(ONE_Q60);
        return 64'(acc);
    endfunction

    function automatic int to_q15_mag(input logic [63:0] v);
        logic [63:0] q40;
        q40 = v >> 20;
        return int'((q40 * 64'd32767 + (64'd1 << 39)) >> 40);
    endfunction

    task automatic build_trig_tables();
        logic [63:0] frac;
        logic [63:0] x;
        for (int r = 0; r < QTR_LEN; r++)
        begin
            frac       = 64'(r);
            frac       = frac << (62 - TRIG_PHASE_BITS);
            x          = fx_mul(frac, HALFPI_Q60);
            sin_mag[r] = to_q15_mag(quarter_series(x, 1'b1));
            cos_mag[r] = to_q15_mag(quarter_series(x, 1'b0));
        end
    endtask

    // ---------------------------------------------------------------
    // Corrected angle for the current register settings
    // ---------------------------------------------------------------

    function automatic logic [ANGLE_W-1:0] corrected_of(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0]         ka;
        logic [TRIG_PHASE_BITS-1:0] ph;
        logic [QTR_BITS-1:0]        ofs;
        logic [1:0]                 quad;
        int                         s_val;
        int                         c_val;
        longint                     acc;
        longint                     corr;
        if (!cfg_enable)
            return a;
        acc = 0;
        for (int k = 1; k <= HARMONICS; k++)
        begin
            ka   = ANGLE_W'(k * a);
            ph   = ka[ANGLE_W-1 -: TRIG_PHASE_BITS];
            ofs  = ph[QTR_BITS-1:0];
            quad = ph[TRIG_PHASE_BITS-1 -: 2];
            case (quad)
                QUAD_0:
                begin
                    s_val = sin_mag[ofs];
                    c_val = cos_mag[ofs];
                end
                QUAD_1:
                begin
                    s_val = cos_mag[ofs];
                    c_val = -sin_mag[ofs];
                end
                QUAD_2:
                begin
                    s_val = -sin_mag[ofs];
                    c_val = -cos_mag[ofs];
                end
                default:
                begin
                    s_val = -cos_mag[ofs];
                    c_val = sin_mag[ofs];
                end
            endcase
            acc = acc + longint'(cfg_sin[k-1]) * s_val + longint'(cfg_cos[k-1]) * c_val;
        end
        // arithmetic shift floors toward minus infinity
        corr = (acc >>> CORR_SHIFT) + longint'(cfg_dc);
        return ANGLE_W'(longint'(a) - corr);
    endfunction

    // ---------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------

    task automatic report_error(input string what);
        if (error_count < 10)
            $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // One APB transfer: setup, access, then one cycle with psel low
    task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] unused;
        apb_xfer(1'b1, idx, value, unused);
        case (idx)
            REG_ENABLE:    cfg_enable = value[0];
            REG_DC_OFFSET: cfg_dc     = value[WEIGHT_W-1:0];
            REG_SIN_W1:    cfg_sin[0] = value[WEIGHT_W-1:0];
            REG_COS_W1:    cfg_cos[0] = value[WEIGHT_W-1:0];
            REG_SIN_W2:    cfg_sin[1] = value[WEIGHT_W-1:0];
            REG_COS_W2:    cfg_cos[1] = value[WEIGHT_W-1:0];
            REG_SIN_W3:    cfg_sin[2] = value[WEIGHT_W-1:0];
            default:       cfg_cos[2] = value[WEIGHT_W-1:0];
        endcase
    endtask

    // Read every register back and compare the implemented bits
    task automatic check_regs();
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    got;
        logic [DATA_W-1:0]    want;
        logic [DATA_W-1:0]    mask;
        for (int i = 0; i < 8; i++)
        begin
            idx = REG_IDX_W'(i);
            apb_xfer(1'b0, idx, '0, got);
            mask = (idx == REG_ENABLE) ? 32'h1 : 32'hFFFF;
            case (idx)
                REG_ENABLE:    want = 32'(cfg_enable);
                REG_DC_OFFSET: want = 32'(cfg_dc);
                REG_SIN_W1:    want = 32'(cfg_sin[0]);
                REG_COS_W1:    want = 32'(cfg_cos[0]);
                REG_SIN_W2:    want = 32'(cfg_sin[1]);
                REG_COS_W2:    want = 32'(cfg_cos[1]);
                REG_SIN_W3:    want = 32'(cfg_sin[2]);
                default:       want = 32'(cfg_cos[2]);
            endcase
            reads_checked++;
            if ((got & mask) !== (want & mask))
                report_error($sformatf("register %0d read %h, expected %h",
                                       i, got & mask, want & mask));
        end
    endtask

    // Offer one raw beat, with random idle cycles ahead of it
    task automatic send_angle(input logic [ANGLE_W-1:0] a);
        pending_t entry;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            raw_valid <= 1'b0;
            @(posedge clk);
        end
        raw_valid    <= 1'b1;
        sensor_angle <= a;
        @(posedge clk);
        while (raw_stall)
            @(posedge clk);
        entry.raw  = a;
        entry.want = corrected_of(a);
        expected_angles.push_back(entry);
        beats_sent++;
    endtask

    // Stop sending and let the pipe empty before touching registers
    task automatic quiesce();
        raw_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_weight_word();
        logic [DATA_W-1:0] w;
        int                roll;
        w    = $urandom;
        roll = $urandom_range(99);
        if (roll < 10)
            w[WEIGHT_W-1:0] = 16'h7FFF;
        else if (roll < 20)
            w[WEIGHT_W-1:0] = 16'h8000;
        else if (roll < 28)
            w[WEIGHT_W-1:0] = 16'h0000;
        else if (roll < 40)
            w[WEIGHT_W-1:0] = 16'($signed($urandom_range(0, 2000)) - 1000);
        return w;
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] a;
        a = ANGLE_W'($urandom);
        if ($urandom_range(99) < 10)
        begin
            case ($urandom_range(5))
                0:       a = 16'h0000;
                1:       a = 16'hFFFF;
                2:       a = 16'h4000;
                3:       a = 16'h8000;
                4:       a = 16'hC000;
                default: a = {a[15:4], 4'h0} - 16'(a[0]);
            endcase
        end
        return a;
    endfunction

    task automatic random_setting();
        logic [DATA_W-1:0] w;
        w    = $urandom;
        w[0] = ($urandom_range(99) < 85);
        write_reg(REG_ENABLE, w);
        for (int i = 1; i < 8; i++)
            write_reg(REG_IDX_W'(i), pick_weight_word());
        check_regs();
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall, or a long hold-off when asked
    // ---------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                corr_stall <= 1'b1;
                hold_left  = hold_left - 1;
            end
            else
                corr_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Result check against the oldest expected beat
    // ---------------------------------------------------------------

    initial
    begin
        pending_t entry;
        forever
        begin
            @(posedge clk);
            if (rst_n && corr_valid && !corr_stall)
            begin
                if (expected_angles.size() == 0)
                    report_error($sformatf("unexpected result %h", corrected_angle));
                else
                begin
                    entry = expected_angles.pop_front();
                    beats_checked++;
                    if (corrected_angle !== entry.want)
                        report_error($sformatf("raw %h: corrected_angle %h, expected %h",
                                               entry.raw, corrected_angle, entry.want));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any beat or register access
    // ---------------------------------------------------------------

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((raw_valid && !raw_stall) || (corr_valid && !corr_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Registers read zero after reset and angles pass straight through
    task automatic test_reset_state();
        tx_idle_pct = 21;
        rx_idle_pct = 62;
        check_regs();
        send_angle(16'h0000);
        send_angle(16'hFFFF);
        send_angle(16'h8000);
        send_angle(16'h5555);
        quiesce();
    endtask

    // Largest and smallest coefficients, junk in the unused upper bits,
    // quadrant boundaries and wrap of large corrections
    task automatic test_extreme_settings();
        write_reg(REG_ENABLE, 32'hFFFF_FFFF);
        write_reg(REG_DC_OFFSET, 32'hABCD_7FFF);
        for (int i = 2; i < 8; i++)
            write_reg(REG_IDX_W'(i), 32'h1234_7FFF);
        check_regs();
        settings_used++;
        send_angle(16'h0000);
        send_angle(16'h0400);
        send_angle(16'h4000);
        send_angle(16'h8000);
        send_angle(16'hC000);
        send_angle(16'hFFFF);
        send_angle(16'h3FF0);
        send_angle(16'h5555);
        quiesce();

        write_reg(REG_DC_OFFSET, 32'h5A5A_8000);
        for (int i = 2; i < 8; i++)
            write_reg(REG_IDX_W'(i), 32'hFFFF_8000);
        check_regs();
        settings_used++;
        send_angle(16'h0000);
        send_angle(16'h1000);
        send_angle(16'h7FFF);
        send_angle(16'hAAAA);
        send_angle(16'hBFFF);
        send_angle(16'hFFFF);
        quiesce();

        // disabled with nonzero weights: still a pass-through
        write_reg(REG_ENABLE, 32'hFFFF_FFFE);
        check_regs();
        settings_used++;
        send_angle(16'h1234);
        send_angle(16'hFEDC);
        quiesce();
    endtask

    // Random settings and angles under the three idle mixes
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 62;
                end
                1:
                begin
                    tx_idle_pct = 62;
                    rx_idle_pct = 21;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 5; blk++)
            begin
                random_setting();
                for (int n = 0; n < PHASE_BLOCK; n++)
                    send_angle(pick_angle());
                quiesce();
            end
        end
    endtask

    // Output held off for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_setting();
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 64; n++)
            send_angle(pick_angle());
        raw_valid <= 1'b0;
        while (hold_left > 0)
            @(posedge clk);
        quiesce();
    endtask

    initial
    begin
        cfg_enable = 1'b0;
        cfg_dc     = '0;
        for (int i = 0; i < WEIGHT_SETS; i++)
        begin
            cfg_sin[i] = '0;
            cfg_cos[i] = '0;
        end
        build_trig_tables();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_extreme_settings();
        test_random_traffic();
        test_output_backpressure();

        raw_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_angles.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_angles.size()));

        $display("testbench: %0d raw beats, %0d results checked, %0d register settings,",
                 beats_sent, beats_checked, settings_used);
        $display("testbench: %0d register reads, three idle mixes and a %0d-cycle hold-off",
                 reads_checked, HOLD_CYCLES);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
